>>> hdl/mexp_pkg.sv
package mexp_pkg;

  // Operand width: every residue is below the prime, which fits in 30 bits.
  localparam int DATA_W = 30;

  // Number of exponent bits scanned per transaction, most significant first.
  localparam int EXP_BITS = 30;
  localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  // Shared multiplier operand width and product width.
  localparam int MUL_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Width of the Barrett remainder before the final correction.
  localparam int REM_W = DATA_W + 2;

  // The prime modulus and the exponent that yields the inverse.
  localparam logic [DATA_W-1:0] PRIME_MOD = DATA_W'(1000000007);
  localparam logic [EXP_BITS-1:0] INV_EXP = EXP_BITS'(1000000005);

  // Barrett constant: floor(2^60 / PRIME_MOD).
  localparam logic [MUL_W-1:0] BARRETT_MU = MUL_W'(1152921496);

  // Operation codes.
  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_QUOT,
    ST_QP,
    ST_FIX,
    ST_DONE
  } mexp_state_e;

  // Datapath step selected by the controller.
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_PROD,
    STEP_QUOT,
    STEP_QP,
    STEP_FIX
  } mexp_step_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    mexp_step_e step;
    logic       use_base;
    logic       exp_shift;
  } mexp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_msb;
  } mexp_status_t;

endpackage

>>> hdl/mexp_datapath.sv
module mexp_datapath (
  input  logic                       clk_i,
  input  mexp_pkg::mexp_cmd_t        cmd_i,
  input  logic                       op_i,
  input  logic [mexp_pkg::DATA_W-1:0] base_i,
  input  logic [mexp_pkg::DATA_W-1:0] exponent_i,
  output mexp_pkg::mexp_status_t     status_o,
  output logic [mexp_pkg::DATA_W-1:0] result_o
);
  import mexp_pkg::*;

  logic [DATA_W-1:0]   acc_q, acc_d;
  logic [DATA_W-1:0]   base_q, base_d;
  logic [EXP_BITS-1:0] exp_q, exp_d;
  logic [PROD_W-1:0]   mul_q, mul_d;
  logic [REM_W-1:0]    xlo_q, xlo_d;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [REM_W-1:0]    rem;
  logic [REM_W:0]      rem_m1, rem_m2;
  logic [DATA_W-1:0]   acc_fix;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.step)
      STEP_PROD: begin
        mul_a = {1'b0, acc_q};
        mul_b = cmd_i.use_base ? {1'b0, base_q} : {1'b0, acc_q};
      end
      STEP_QUOT: begin
        // Quotient estimate: (x >> 29) * mu, later shifted right by 31.
        mul_a = mul_q[DATA_W-1 +: MUL_W];
        mul_b = BARRETT_MU;
      end
      STEP_QP: begin
        mul_a = mul_q[MUL_W +: MUL_W];
        mul_b = {1'b0, PRIME_MOD};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The remainder is below three times the prime, so the low bits suffice.
  assign rem    = xlo_q - mul_q[REM_W-1:0];
  assign rem_m1 = {1'b0, rem} - (REM_W+1)'(PRIME_MOD);
  assign rem_m2 = {1'b0, rem} - ((REM_W+1)'(PRIME_MOD) << 1);

  // Final correction: subtract the prime zero, one or two times.
  always_comb begin
    if (!rem_m2[REM_W]) begin
      acc_fix = rem_m2[DATA_W-1:0];
    end else if (!rem_m1[REM_W]) begin
      acc_fix = rem_m1[DATA_W-1:0];
    end else begin
      acc_fix = rem[DATA_W-1:0];
    end
  end

  // Next values of the datapath registers.
  always_comb begin
    acc_d  = acc_q;
    base_d = base_q;
    exp_d  = exp_q;
    mul_d  = mul_q;
    xlo_d  = xlo_q;
    if (cmd_i.load) begin
      acc_d  = DATA_W'(1);
      // A base up to 2^30-1 is below twice the prime, so one subtraction reduces it.
      base_d = (base_i >= PRIME_MOD) ? base_i - PRIME_MOD : base_i;
      exp_d  = (op_i == OP_INVERSE) ? INV_EXP : EXP_BITS'(exponent_i);
    end
    if (cmd_i.step == STEP_PROD || cmd_i.step == STEP_QUOT || cmd_i.step == STEP_QP) begin
      mul_d = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
    end
    if (cmd_i.step == STEP_QUOT) begin
      xlo_d = mul_q[REM_W-1:0];
    end
    if (cmd_i.step == STEP_FIX) begin
      acc_d = acc_fix;
    end
    if (cmd_i.exp_shift) begin
      exp_d = exp_q << 1;
    end
  end

  // Datapath registers carry payload only and need no reset.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    mul_q  <= mul_d;
    xlo_q  <= xlo_d;
  end

  assign status_o.exp_msb = exp_q[EXP_BITS-1];
  assign result_o         = acc_q;

endmodule

>>> hdl/mexp_ctrl.sv
module mexp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  mexp_pkg::mexp_status_t status_i,
  output mexp_pkg::mexp_cmd_t    cmd_o,
  output logic                   busy,
  output logic                   done_o
);
  import mexp_pkg::*;

  mexp_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             mult_q, mult_d;
  logic             advance;

  // After a squaring with the current bit set, a multiply by the base follows.
  assign advance = mult_q || !status_i.exp_msb;

  // Next state, bit counter and phase flag.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mult_d  = mult_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_PROD;
          cnt_d   = CNT_W'(EXP_BITS - 1);
          mult_d  = 1'b0;
        end
      end
      ST_PROD: state_d = ST_QUOT;
      ST_QUOT: state_d = ST_QP;
      ST_QP:   state_d = ST_FIX;
      ST_FIX: begin
        if (!advance) begin
          state_d = ST_PROD;
          mult_d  = 1'b1;
        end else if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PROD;
          cnt_d   = cnt_q - CNT_W'(1);
          mult_d  = 1'b0;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath and handshake outputs.
  always_comb begin
    cmd_o.load      = 1'b0;
    cmd_o.step      = STEP_NONE;
    cmd_o.use_base  = mult_q;
    cmd_o.exp_shift = 1'b0;
    busy            = 1'b1;
    done_o          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_PROD: cmd_o.step = STEP_PROD;
      ST_QUOT: cmd_o.step = STEP_QUOT;
      ST_QP:   cmd_o.step = STEP_QP;
      ST_FIX: begin
        cmd_o.step      = STEP_FIX;
        cmd_o.exp_shift = advance;
      end
      ST_DONE: done_o = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      mult_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mult_q  <= mult_d;
    end
  end

endmodule

>>> hdl/modular_exponentiation_core.sv
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      op_i, base_i, exponent_i
// result    out        done_o strobe, one cycle  result_o
//
// Each modular multiply runs in four steps on one shared 31x31 multiplier:
// product, Barrett quotient estimate, quotient times prime, then subtract
// and correct. A transaction squares once for each of the 30 exponent bits
// and multiplies once by the base for each set bit; the next command is
// accepted only after done_o, once the block is idle again.
// Reset is asynchronous and active low; it clears only the controller.
// The receiver cannot stall: result_o is valid only in the done_o cycle.
module modular_exponentiation_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [mexp_pkg::DATA_W-1:0] base_i,
  input  logic [mexp_pkg::DATA_W-1:0] exponent_i,
  output logic                        done_o,
  output logic [mexp_pkg::DATA_W-1:0] result_o
);
  import mexp_pkg::*;

  mexp_cmd_t    cmd;
  mexp_status_t status;

  // Sequencer for the square-and-multiply scan.
  mexp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // Multiplier, Barrett reduction and operand registers.
  mexp_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .op_i       (op_i),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .status_o   (status),
    .result_o   (result_o)
  );

  // An accepted transaction makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting a transaction");

  // A delivered result is always fully reduced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o < PRIME_MOD))
    else $error("result not reduced below the prime");

  // The result strobe lasts one cycle and the block is free right after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe not followed by idle");

  // The strobe only appears while a transaction is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

endmodule
